@@ rtl/vcfc_pkg.sv @@
// Shared types and constants for the voxel chunk face-cull store.
// Used by vcfc_nbr_sel, voxel_chunk_face_cull_store, vcfc_store_checker and the testbench; no dependencies.
package vcfc_pkg;

  localparam int COORD_W  = 5;
  localparam int ID_W     = 24;
  localparam int WORD_W   = 30;
  localparam int COUNT_W  = 13;
  localparam int FACE_LSB = 24;
  localparam int FACE_N   = 6;

  localparam logic [WORD_W-1:0] FACES_ALL = 30'h3F00_0000;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Neighbour walk: left, right, bottom, top, back, front (face bits 24..29)
  localparam logic [2:0] NB_LAST = 3'd5;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } vcfc_axis_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_NB_RD,
    S_NB_WR,
    S_CTR_WR,
    S_FINISH
  } vcfc_state_t;

  typedef struct packed {
    logic              op;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [ID_W-1:0]    block_id;
  } vcfc_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  block_word;
    logic [COUNT_W-1:0] occupied_count;
  } vcfc_rsp_t;

  // Neighbour selection result
  typedef struct packed {
    logic              valid;
    logic [FACE_N-1:0] own_face;
    logic [FACE_N-1:0] far_face;
  } vcfc_nb_info_t;

endpackage

@@ rtl/vcfc_nbr_sel.sv @@
// Neighbour address and face-mask selection for one step of the face walk.
// Depends on vcfc_pkg.
module vcfc_nbr_sel import vcfc_pkg::*; #(
  parameter int EDGE_CELLS = 16,
  parameter int CW         = 4
) (
  input  logic [CW-1:0]   cx,
  input  logic [CW-1:0]   cy,
  input  logic [CW-1:0]   cz,
  input  logic [2:0]      dir,
  output logic [3*CW-1:0] nb_addr,
  output vcfc_nb_info_t   info
);

  logic [CW-1:0] c;
  logic [CW-1:0] n;
  logic [CW-1:0] nx;
  logic [CW-1:0] ny;
  logic [CW-1:0] nz;
  logic          minus;
  logic          in_cube;

  always_comb begin
    minus = ~dir[0];
    case (vcfc_axis_t'(dir[2:1]))
      AX_X:    c = cx;
      AX_Y:    c = cy;
      default: c = cz;
    endcase
    n       = minus ? c - CW'(1) : c + CW'(1);
    in_cube = minus ? (c != '0) : (c != CW'(EDGE_CELLS - 1));
    nx = cx;
    ny = cy;
    nz = cz;
    case (vcfc_axis_t'(dir[2:1]))
      AX_X:    nx = n;
      AX_Y:    ny = n;
      default: nz = n;
    endcase
    nb_addr       = {nz, ny, nx};
    info.valid    = in_cube && (dir <= NB_LAST);
    info.own_face = 6'b000001 << dir;
    info.far_face = 6'b000001 << (dir ^ 3'b001);
  end

endmodule

@@ rtl/voxel_chunk_face_cull_store.sv @@
// Top level of the voxel chunk face-cull store: sequencer, cell memory, counters.
// Depends on vcfc_pkg and vcfc_nbr_sel.
//
// Holds a cube of EDGE_CELLS cells a side; each 30-bit word carries a block id
// (low ID_BITS bits) and six visible-face bits (left, right, bottom, top,
// back, front on bits 24..29). A set beat places a nonzero id in an empty cell
// and culls the faces it shares with occupied neighbours, or clears an occupied
// cell and restores its neighbours' faces; a get beat returns the stored word.
// Each request beat yields exactly one response beat carrying the occupied
// count. All cells live in one single-port memory with registered read data.
// A get, an out-of-range request or a set that changes nothing answers once
// its cell has been read; a set or clear that changes a cell first walks the
// six neighbours, reading each one inside the cube and skipping each outside
// it, then writes the cell back before it answers. The block takes one
// request at a time; a finished response waits in its own register, so the
// next request is taken while it is still stalled. After reset the memory is
// swept to zero, one word a cycle, over all 2**(3*ceil(log2(EDGE_CELLS)))
// words (4096 at the default size); req_stall stays high throughout.
module voxel_chunk_face_cull_store import vcfc_pkg::*; #(
  parameter int EDGE_CELLS = 16,
  parameter int ID_BITS    = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  vcfc_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output vcfc_rsp_t rsp
);

  localparam int CW    = (EDGE_CELLS > 1) ? $clog2(EDGE_CELLS) : 1;
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int CELLS = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;

  localparam logic [COORD_W-1:0] EDGE_LIM = COORD_W'(EDGE_CELLS);
  localparam logic [ID_W-1:0]    ID_MASK  = ID_W'((33'd1 << ID_BITS) - 33'd1);

  // Sequencer state
  vcfc_state_t state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [2:0]    nb_idx, nb_idx_next;
  logic          place, place_next;

  // Latched request
  logic          op_r;
  logic          in_range;
  logic [CW-1:0] cx, cy, cz;
  logic [ID_W-1:0] id_r;

  // Working words and the occupied count
  logic [WORD_W-1:0]  work_word, work_word_next;
  logic [WORD_W-1:0]  res_word, res_word_next;
  logic [COUNT_W-1:0] block_total, total_next;

  // Memory port
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;

  logic          req_accept;
  logic          rsp_load;
  logic [AW-1:0] ctr_addr;
  logic [AW-1:0] nb_addr;
  vcfc_nb_info_t nb_info;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign ctr_addr   = {cz, cy, cx};

  vcfc_nbr_sel #(
    .EDGE_CELLS (EDGE_CELLS),
    .CW         (CW)
  ) u_nbr_sel (
    .cx      (cx),
    .cy      (cy),
    .cz      (cz),
    .dir     (nb_idx),
    .nb_addr (nb_addr),
    .info    (nb_info)
  );

  // Single-port cell memory, read-first, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Latch the request beat; out-of-range coordinates are flagged so the beat touches no cell
  always_ff @(posedge clk) begin
    if (req_accept) begin
      op_r     <= req.op;
      in_range <= (req.coord_x < EDGE_LIM) && (req.coord_y < EDGE_LIM) &&
                  (req.coord_z < EDGE_LIM);
      cx       <= req.coord_x[CW-1:0];
      cy       <= req.coord_y[CW-1:0];
      cz       <= req.coord_z[CW-1:0];
      id_r     <= req.block_id & ID_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      nb_idx      <= '0;
      place       <= 1'b0;
      block_total <= '0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      nb_idx      <= nb_idx_next;
      place       <= place_next;
      block_total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    work_word <= work_word_next;
    res_word  <= res_word_next;
  end

  // Response register: hold while stalled, reload once the old beat has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.block_word     <= res_word;
      rsp.occupied_count <= block_total;
    end
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    nb_idx_next    = nb_idx;
    place_next     = place;
    work_word_next = work_word;
    res_word_next  = res_word;
    total_next     = block_total;
    mem_we         = 1'b0;
    mem_addr       = ctr_addr;
    mem_wdata      = '0;
    rsp_load       = 1'b0;
    case (state)
      S_CLEAR: begin
        // Sweep the whole memory to empty after reset
        mem_we        = 1'b1;
        mem_addr      = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // Read the addressed cell
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        res_word_next = '0;
        nb_idx_next   = '0;
        state_next    = S_FINISH;
        if (in_range) begin
          if (op_r == OP_GET) begin
            res_word_next = rdata;
          end else if ((rdata == '0) && (id_r != '0)) begin
            // Place: start with every face visible, cull during the walk
            place_next     = 1'b1;
            work_word_next = FACES_ALL | {{(WORD_W-ID_W){1'b0}}, id_r};
            total_next     = block_total + COUNT_W'(1);
            state_next     = S_NB_RD;
          end else if ((rdata != '0) && (id_r == '0)) begin
            place_next = 1'b0;
            total_next = block_total - COUNT_W'(1);
            state_next = S_NB_RD;
          end
        end
      end
      S_NB_RD: begin
        mem_addr = nb_addr;
        if (nb_info.valid) begin
          state_next = S_NB_WR;
        end else if (nb_idx == NB_LAST) begin
          state_next = S_CTR_WR;
        end else begin
          nb_idx_next = nb_idx + 3'd1;
        end
      end
      S_NB_WR: begin
        // Toggle the shared face on an occupied neighbour
        mem_addr = nb_addr;
        if (rdata != '0) begin
          mem_we    = 1'b1;
          mem_wdata = rdata ^ {nb_info.far_face, {FACE_LSB{1'b0}}};
          if (place) begin
            work_word_next = work_word ^ {nb_info.own_face, {FACE_LSB{1'b0}}};
          end
        end
        if (nb_idx == NB_LAST) begin
          state_next = S_CTR_WR;
        end else begin
          nb_idx_next = nb_idx + 3'd1;
          state_next  = S_NB_RD;
        end
      end
      S_CTR_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = place ? work_word : '0;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Occupied count never exceeds the cube size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    block_total <= COUNT_W'(CELLS))
    else $error("occupied count above cube size");

  // The count moves only on the decision step of a set or clear
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (block_total != $past(block_total)) |-> ($past(state) == S_DECIDE))
    else $error("occupied count changed outside decision step");

  // Centre write-back only follows an in-range set
  a_ctr_wr: assert property (@(posedge clk) disable iff (rst)
    (state == S_CTR_WR) |-> ((op_r == OP_SET) && in_range))
    else $error("cell write-back without an in-range set");

  // An accepted beat always starts with the lookup of its cell
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> (state == S_LOOKUP))
    else $error("accepted beat did not start a lookup");
`endif

endmodule

@@ test/vcfc_store_checker.sv @@
// Checker for the voxel chunk face-cull store: watches both channels, keeps its own
// copy of the cell store and compares every response beat with the predicted one.
// Depends on vcfc_pkg only.
module vcfc_store_checker
  import vcfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  vcfc_req_t req,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  vcfc_rsp_t rsp,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CUBE_EDGE = 16;
  localparam int CELL_COUNT = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << 24) - 1);

  localparam logic [WORD_W-1:0] FACE_LEFT   = 30'h0100_0000;
  localparam logic [WORD_W-1:0] FACE_RIGHT  = 30'h0200_0000;
  localparam logic [WORD_W-1:0] FACE_BOTTOM = 30'h0400_0000;
  localparam logic [WORD_W-1:0] FACE_TOP    = 30'h0800_0000;
  localparam logic [WORD_W-1:0] FACE_BACK   = 30'h1000_0000;
  localparam logic [WORD_W-1:0] FACE_FRONT  = 30'h2000_0000;

  logic [WORD_W-1:0]  cell_words [CELL_COUNT];
  logic [COUNT_W-1:0] placed_total;
  vcfc_rsp_t          rsp_due [$];
  int                 errors = 0;

  function automatic bit in_cube(int x, int y, int z);
    return x >= 0 && x < CUBE_EDGE && y >= 0 && y < CUBE_EDGE && z >= 0 && z < CUBE_EDGE;
  endfunction

  // Flip one face on a neighbour; report whether that neighbour holds a block.
  function automatic bit flip_neighbour_face(int x, int y, int z, logic [WORD_W-1:0] face);
    int idx;
    if (!in_cube(x, y, z)) return 1'b0;
    idx = x + CUBE_EDGE * y + CUBE_EDGE * CUBE_EDGE * z;
    if (cell_words[idx] == '0) return 1'b0;
    cell_words[idx] ^= face;
    return 1'b1;
  endfunction

  function automatic vcfc_rsp_t apply_voxel_beat(vcfc_req_t beat);
    int x, y, z, idx;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] w;
    vcfc_rsp_t         r;
    x = int'(beat.coord_x);
    y = int'(beat.coord_y);
    z = int'(beat.coord_z);
    id = beat.block_id & ID_MASK;
    r = '0;
    if (in_cube(x, y, z)) begin
      idx = x + CUBE_EDGE * y + CUBE_EDGE * CUBE_EDGE * z;
      if (beat.op == OP_GET) begin
        r.block_word = cell_words[idx];
      end else if (cell_words[idx] == '0 && id != '0) begin
        w = FACES_ALL | {{(WORD_W - ID_W){1'b0}}, id};
        placed_total = placed_total + 1'b1;
        if (flip_neighbour_face(x - 1, y, z, FACE_RIGHT))  w ^= FACE_LEFT;
        if (flip_neighbour_face(x + 1, y, z, FACE_LEFT))   w ^= FACE_RIGHT;
        if (flip_neighbour_face(x, y, z - 1, FACE_FRONT))  w ^= FACE_BACK;
        if (flip_neighbour_face(x, y, z + 1, FACE_BACK))   w ^= FACE_FRONT;
        if (flip_neighbour_face(x, y - 1, z, FACE_TOP))    w ^= FACE_BOTTOM;
        if (flip_neighbour_face(x, y + 1, z, FACE_BOTTOM)) w ^= FACE_TOP;
        cell_words[idx] = w;
      end else if (cell_words[idx] != '0 && id == '0) begin
        cell_words[idx] = '0;
        placed_total = placed_total - 1'b1;
        void'(flip_neighbour_face(x - 1, y, z, FACE_RIGHT));
        void'(flip_neighbour_face(x + 1, y, z, FACE_LEFT));
        void'(flip_neighbour_face(x, y, z - 1, FACE_FRONT));
        void'(flip_neighbour_face(x, y, z + 1, FACE_BACK));
        void'(flip_neighbour_face(x, y - 1, z, FACE_TOP));
        void'(flip_neighbour_face(x, y + 1, z, FACE_BOTTOM));
      end
    end
    r.occupied_count = placed_total;
    return r;
  endfunction

  always @(posedge clk) begin
    vcfc_rsp_t want;
    if (rst) begin
      foreach (cell_words[i]) cell_words[i] = '0;
      placed_total = '0;
      rsp_due.delete();
    end else begin
      if (req_valid && !req_stall) rsp_due.push_back(apply_voxel_beat(req));
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected response beat, got word %h count %0d",
                   $time, rsp.block_word, rsp.occupied_count);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.block_word !== want.block_word) begin
            errors++;
            $display("%0t: block_word mismatch, expected %h, got %h",
                     $time, want.block_word, rsp.block_word);
          end
          if (rsp.occupied_count !== want.occupied_count) begin
            errors++;
            $display("%0t: occupied_count mismatch, expected %0d, got %0d",
                     $time, want.occupied_count, rsp.occupied_count);
          end
        end
      end
    end
    fail_count <= errors;
    pending_count <= rsp_due.size();
  end

endmodule

@@ test/voxel_chunk_face_cull_store_test.sv @@
// Testbench top for the voxel chunk face-cull store: clock, reset, request and
// response drivers, and the verdict. Depends on vcfc_pkg, the block and vcfc_store_checker.
module voxel_chunk_face_cull_store_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vcfc_pkg::*;

  // The run bound covers the post-reset sweep and every beat with its longest
  // gap and stall, so this bound leaves plenty of headroom.
  localparam int RUN_LIMIT    = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BEATS = 700;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  vcfc_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  vcfc_rsp_t rsp;

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  // Hand-off from the request driver to the response driver.
  bit hold_ask;   // ask the receiver for one long hold-off
  bit rsp_eager;  // receiver takes every beat at once

  voxel_chunk_face_cull_store #(
    .EDGE_CELLS (16),
    .ID_BITS    (24)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  vcfc_store_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Corners matter for the out-of-cube neighbour rule, so bias clusters onto them.
  function automatic int cluster_base();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 0;
    if (r == 1) return 12;
    return $urandom_range(0, 12);
  endfunction

  function automatic vcfc_req_t beat_of(logic op, int x, int y, int z, logic [ID_W-1:0] id);
    vcfc_req_t b;
    b.op       = op;
    b.coord_x  = x[COORD_W-1:0];
    b.coord_y  = y[COORD_W-1:0];
    b.coord_z  = z[COORD_W-1:0];
    b.block_id = id;
    return b;
  endfunction

  // Idle for the given number of cycles, then offer the beat and hold it until
  // it is taken. Valid stays high across back-to-back beats.
  task automatic send_beat(input vcfc_req_t beat, input int gap);
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Response side: random stall runs, one long hold-off on request, and free
  // flow while the steady stretch runs.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask && !hold_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        rsp_stall <= 1'b0;
      end else if (rsp_eager) begin
        stall_left = 0;
        rsp_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
        rsp_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // Request side and verdict.
  initial begin
    int        i, gap, kind, bx, by, bz;
    vcfc_req_t b;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    hold_ask = 1'b0;
    rsp_eager = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty read, a corner block and its three neighbours, a set on an
    // occupied cell, clear twice (second one hits an empty cell), the far corner,
    // out-of-range sets on every axis, out-of-range gets and a clear, then unwind.
    send_beat(beat_of(OP_GET, 0, 0, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 0, 0, 0, 24'hFFFFFF), pick_gap());
    send_beat(beat_of(OP_SET, 1, 0, 0, 24'h000001), pick_gap());
    send_beat(beat_of(OP_SET, 0, 1, 0, 24'hABCDEF), pick_gap());
    send_beat(beat_of(OP_SET, 0, 0, 1, 24'h123456), pick_gap());
    send_beat(beat_of(OP_GET, 0, 0, 0, 24'hFFFFFF), pick_gap());
    send_beat(beat_of(OP_GET, 1, 0, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 0, 0, 0, 24'h000005), pick_gap());
    send_beat(beat_of(OP_SET, 1, 0, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 1, 0, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_GET, 0, 0, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 15, 15, 15, 24'h800000), pick_gap());
    send_beat(beat_of(OP_SET, 14, 15, 15, 24'h7FFFFF), pick_gap());
    send_beat(beat_of(OP_SET, 15, 14, 15, 24'h555555), pick_gap());
    send_beat(beat_of(OP_GET, 15, 15, 15, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 16, 0, 0, 24'h000010), pick_gap());
    send_beat(beat_of(OP_SET, 0, 31, 0, 24'h000011), pick_gap());
    send_beat(beat_of(OP_SET, 0, 0, 20, 24'h000012), pick_gap());
    send_beat(beat_of(OP_GET, 31, 31, 31, 24'hFFFFFF), pick_gap());
    send_beat(beat_of(OP_GET, 16, 3, 3, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 16, 0, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 0, 0, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_GET, 0, 1, 0, 24'h000000), pick_gap());
    send_beat(beat_of(OP_GET, 14, 15, 15, 24'h000000), pick_gap());
    send_beat(beat_of(OP_SET, 15, 15, 15, 24'h000000), pick_gap());

    // Random: work inside a 4x4x4 cluster so neighbours meet often, move the
    // cluster every 50 beats, and mix in noise across the whole coordinate range.
    bx = 0;
    by = 0;
    bz = 0;
    for (i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 50 == 0) begin
        bx = cluster_base();
        by = cluster_base();
        bz = cluster_base();
      end
      // Long receiver hold-off while beats keep coming: the block fills and stalls.
      if (i == 200) hold_ask = 1'b1;
      // Drop valid and let the block drain completely before carrying on.
      if (i == 400) begin
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
      // Steady stretch with no idling on either side.
      if (i == 500) rsp_eager = 1'b1;
      if (i == 560) rsp_eager = 1'b0;

      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        b = beat_of(OP_SET, bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                    bz + $urandom_range(0, 3), 24'($urandom_range(1, 24'hFFFFFF)));
      end else if (kind < 60) begin
        b = beat_of(OP_SET, bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                    bz + $urandom_range(0, 3), 24'h000000);
      end else if (kind < 90) begin
        b = beat_of(OP_GET, bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                    bz + $urandom_range(0, 3), 24'($urandom));
      end else begin
        b = beat_of(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 31),
                    ($urandom_range(0, 3) == 0) ? 24'h0 : 24'($urandom));
      end

      gap = ((i >= 200 && i < 224) || (i >= 500 && i < 560)) ? 0 : pick_gap();
      send_beat(b, gap);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ voxel_chunk_face_cull_store.f @@
rtl/vcfc_pkg.sv
rtl/vcfc_nbr_sel.sv
rtl/voxel_chunk_face_cull_store.sv
test/vcfc_store_checker.sv
test/voxel_chunk_face_cull_store_test.sv
